// ===== sv/wfha_pkg.sv =====
package wfha_pkg;

    // region geometry
    localparam int HEAP_BYTES   = 4096;
    localparam int GROW_UNIT    = 32;
    localparam int HEADER_BYTES = 16;

    // widths
    localparam int ADDR_W = $clog2(HEAP_BYTES);   // header store index
    localparam int TOP_W  = ADDR_W + 1;           // heap top, 0 .. HEAP_BYTES
    localparam int PTR_W  = TOP_W + 1;            // walk pointer and sums
    localparam int SIZE_W = TOP_W;                // payload size in a header
    localparam int ENT_W  = SIZE_W + 1;           // occupied mark + size
    localparam int DATA_W = 32;
    localparam int REQ_W  = 12;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FAIL   = 2'd1;
    localparam logic [ST_W-1:0] ST_DOUBLE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [REQ_W-1:0]  req_bytes;
        logic [DATA_W-1:0] release_addr;
    } wfha_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] block_addr;
        logic [ST_W-1:0]   status;
    } wfha_rsp_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ENT_W-1:0]  wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } wfha_mem_req_t;

endpackage

// ===== sv/worst_fit_heap_allocator_top.sv =====
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  opcode, req_bytes, release_addr
// out       output     out_valid / out_stall block_addr, status
// cfg       input      cfg_wr_en            cfg_wr_data (heap_base)
//
// an allocate walks every block header (read, evaluate), then places, writes the
// header and, on a split, the remainder, and hands off; a release walks the headers
// up to its address; clears and up-front rejects hand off; the walk sets the rate
// reset clears the heap top and handshake state; no clearing pass is needed
// in_stall is high while an item is in progress; a stalled result waits in the
// output register while the next item is taken and worked on
module worst_fit_heap_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [wfha_pkg::OP_W-1:0]     opcode,
    input  logic [wfha_pkg::REQ_W-1:0]    req_bytes,
    input  logic [wfha_pkg::DATA_W-1:0]   release_addr,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [wfha_pkg::DATA_W-1:0]   block_addr,
    output logic [wfha_pkg::ST_W-1:0]     status,
    input  logic                          cfg_wr_en,
    input  logic [wfha_pkg::DATA_W-1:0]   cfg_wr_data
);
    import wfha_pkg::*;

    logic [DATA_W-1:0] heap_base_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] block_addr_reg;
    logic [ST_W-1:0]   status_reg;

    wfha_req_t         req;
    wfha_rsp_t         rsp;
    wfha_mem_req_t     mem_req;
    logic [ENT_W-1:0]  mem_rd_data;
    logic              seq_idle;
    logic              rsp_valid;
    logic              rsp_ready;

    assign req.opcode       = opcode;
    assign req.req_bytes    = req_bytes;
    assign req.release_addr = release_addr;

    assign in_stall  = !seq_idle;
    assign rsp_ready = !out_valid_reg || !out_stall;

    wfha_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (in_valid && !in_stall),
        .req         (req),
        .heap_base   (heap_base_reg),
        .idle        (seq_idle),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    wfha_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (mem_rd_data)
    );

    // heap base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            heap_base_reg <= cfg_wr_data;
        end
    end

    // output register, loaded when the slot is free or its transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= rsp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_ready && rsp_valid)
        begin
            block_addr_reg <= rsp.block_addr;
            status_reg     <= rsp.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign block_addr = block_addr_reg;
    assign status     = status_reg;

endmodule

// ===== sv/wfha_mem.sv =====
module wfha_mem (
    input  logic                           clk,
    input  wfha_pkg::wfha_mem_req_t        mem_req,
    output logic [wfha_pkg::ENT_W-1:0]     rd_data
);
    import wfha_pkg::*;

    logic [ENT_W-1:0] mem [HEAP_BYTES];

    // header store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        rd_data <= mem[mem_req.rd_addr];
    end

endmodule

// ===== sv/wfha_seq.sv =====
module wfha_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  wfha_pkg::wfha_req_t           req,
    input  logic [wfha_pkg::DATA_W-1:0]   heap_base,
    output logic                          idle,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output wfha_pkg::wfha_rsp_t           rsp,
    output wfha_pkg::wfha_mem_req_t       mem_req,
    input  logic [wfha_pkg::ENT_W-1:0]    mem_rd_data
);
    import wfha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_PLACE,
        S_WR_HEAD,
        S_WR_REST,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    p_reg, p_next;
    logic [TOP_W-1:0]    heap_top_reg, heap_top_next;
    logic                found_reg, found_next;
    logic [ADDR_W-1:0]   best_reg, best_next;
    logic [SIZE_W-1:0]   best_size_reg, best_size_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [TOP_W-1:0]    off_reg, off_next;
    logic [DATA_W-1:0]   addr_reg, addr_next;
    logic [ST_W-1:0]     status_reg, status_next;

    logic                ent_occ;
    logic [SIZE_W-1:0]   ent_size;
    logic [PTR_W-1:0]    step;
    logic                more;
    logic                fits;
    logic [PTR_W-1:0]    req_up;
    logic [PTR_W-1:0]    grown;
    logic [PTR_W-1:0]    grow_end;
    logic                grow_fail;
    logic [SIZE_W-1:0]   diff;
    logic [PTR_W-1:0]    split_rest;
    logic                split;
    logic [DATA_W-1:0]   off32;
    logic                off_bad;
    logic [DATA_W-1:0]   blk_addr;
    logic                p_hit;
    logic                p_past;

    // header fields of the block under the walk pointer
    assign ent_occ  = mem_rd_data[ENT_W-1];
    assign ent_size = mem_rd_data[SIZE_W-1:0];

    // walk step: the shared pointer adder and its end compare
    assign step = p_reg + PTR_W'(HEADER_BYTES) + PTR_W'(ent_size);
    assign more = step < PTR_W'(heap_top_reg);

    // worst fit candidate test
    assign fits = !ent_occ && (ent_size >= SIZE_W'(req_reg))
                  && (!found_reg || (ent_size > best_size_reg));

    // heap growth when nothing fits
    assign req_up    = PTR_W'(req_reg) + PTR_W'(GROW_UNIT - 1);
    assign grown     = PTR_W'((req_up / GROW_UNIT) * GROW_UNIT);
    assign grow_end  = PTR_W'(heap_top_reg) + PTR_W'(HEADER_BYTES) + grown;
    assign grow_fail = grow_end > PTR_W'(HEAP_BYTES);

    // split of the chosen block
    assign diff       = best_size_reg - SIZE_W'(req_reg);
    assign split_rest = PTR_W'(best_reg) + PTR_W'(HEADER_BYTES) + PTR_W'(req_reg);
    assign split      = (diff > SIZE_W'(HEADER_BYTES)) && (split_rest < PTR_W'(HEAP_BYTES));

    // address translation
    assign off32    = req.release_addr - heap_base - DATA_W'(HEADER_BYTES);
    assign off_bad  = off32 >= DATA_W'(heap_top_reg);
    assign blk_addr = heap_base + DATA_W'(best_reg) + DATA_W'(HEADER_BYTES);
    assign p_hit    = p_reg == PTR_W'(off_reg);
    assign p_past   = p_reg > PTR_W'(off_reg);

    // header store port
    always_comb
    begin
        mem_req.rd_addr = p_reg[ADDR_W-1:0];
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = p_reg[ADDR_W-1:0];
        mem_req.wr_data = {1'b0, ent_size};
        case (state_reg)
            S_EVAL:
            begin
                mem_req.wr_en = (op_reg == OP_RELEASE) && p_hit && ent_occ;
            end
            S_WR_HEAD:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = best_reg;
                mem_req.wr_data = {1'b1, split ? SIZE_W'(req_reg) : best_size_reg};
            end
            S_WR_REST:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = split_rest[ADDR_W-1:0];
                mem_req.wr_data = {1'b0, diff - SIZE_W'(HEADER_BYTES)};
            end
            default:
            begin
                mem_req.wr_en = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        heap_top_next  = heap_top_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_size_next = best_size_reg;
        req_next       = req_reg;
        op_next        = op_reg;
        off_next       = off_reg;
        addr_next      = addr_reg;
        status_next    = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.opcode;
                    req_next    = req.req_bytes;
                    off_next    = off32[TOP_W-1:0];
                    p_next      = '0;
                    found_next  = 1'b0;
                    addr_next   = '0;
                    status_next = ST_FAIL;
                    state_next  = S_DONE;
                    case (req.opcode)
                        OP_ALLOC:
                        begin
                            if (req.req_bytes != '0)
                            begin
                                state_next = (heap_top_reg == '0) ? S_PLACE : S_READ;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (!off_bad)
                            begin
                                state_next = S_READ;
                            end
                        end
                        OP_CLEAR:
                        begin
                            heap_top_next = '0;
                            status_next   = ST_OK;
                        end
                        default:
                        begin
                            status_next = ST_FAIL;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                p_next     = step;
                state_next = more ? S_READ : S_PLACE;
                if (op_reg == OP_ALLOC)
                begin
                    if (fits)
                    begin
                        found_next     = 1'b1;
                        best_next      = p_reg[ADDR_W-1:0];
                        best_size_next = ent_size;
                    end
                end
                else if (p_hit)
                begin
                    status_next = ent_occ ? ST_OK : ST_DOUBLE;
                    state_next  = S_DONE;
                end
                else if (p_past || !more)
                begin
                    state_next = S_DONE;
                end
            end
            S_PLACE:
            begin
                if (found_reg)
                begin
                    state_next = S_WR_HEAD;
                end
                else if (grow_fail)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    best_next      = heap_top_reg[ADDR_W-1:0];
                    best_size_next = grown[SIZE_W-1:0];
                    heap_top_next  = grow_end[TOP_W-1:0];
                    state_next     = S_WR_HEAD;
                end
            end
            S_WR_HEAD:
            begin
                addr_next   = blk_addr;
                status_next = ST_OK;
                state_next  = split ? S_WR_REST : S_DONE;
            end
            S_WR_REST:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            heap_top_reg  <= '0;
            found_reg     <= 1'b0;
            p_reg         <= '0;
            best_reg      <= '0;
            best_size_reg <= '0;
            req_reg       <= '0;
            op_reg        <= OP_ALLOC;
            off_reg       <= '0;
            addr_reg      <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            heap_top_reg  <= heap_top_next;
            found_reg     <= found_next;
            p_reg         <= p_next;
            best_reg      <= best_next;
            best_size_reg <= best_size_next;
            req_reg       <= req_next;
            op_reg        <= op_next;
            off_reg       <= off_next;
            addr_reg      <= addr_next;
            status_reg    <= status_next;
        end
    end

    assign idle           = state_reg == S_IDLE;
    assign rsp_valid      = state_reg == S_DONE;
    assign rsp.block_addr = addr_reg;
    assign rsp.status     = status_reg;

endmodule

// ===== sim/worst_fit_heap_allocator_top_test.sv =====
module worst_fit_heap_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wfha_pkg::*;

    // opcode with no operation behind it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int MAX_WALK = HEAP_BYTES / HEADER_BYTES + 1;
    localparam int CHUNK_ITEMS = 320;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [OP_W-1:0]   opcode;
    logic [REQ_W-1:0]  req_bytes;
    logic [DATA_W-1:0] release_addr;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] block_addr;
    logic [ST_W-1:0]   status;
    logic              cfg_wr_en;
    logic [DATA_W-1:0] cfg_wr_data;

    // heap image kept by the testbench
    logic              hdr_used [HEAP_BYTES];
    logic [SIZE_W-1:0] hdr_size [HEAP_BYTES];
    int unsigned       top_off;
    logic [DATA_W-1:0] base_q;

    // results still to come, oldest first
    wfha_rsp_t         pending_rsp [$];

    // payload offsets of occupied and of released blocks
    int unsigned       live_offs [$];
    int unsigned       freed_offs [$];

    bit                no_idle;
    int                fails;
    int                items_sent;
    int                results_seen;
    int                allocs_ok;
    int                releases_ok;
    int                rejected;
    int                cfg_writes;

    worst_fit_heap_allocator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .req_bytes    (req_bytes),
        .release_addr (release_addr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .block_addr   (block_addr),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // request size: mostly small, a few near the region size
    function automatic logic [REQ_W-1:0] pick_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return '0;
        else if (r < 70)
            return REQ_W'($urandom_range(1, 64));
        else if (r < 90)
            return REQ_W'($urandom_range(65, 512));
        else if (r < 98)
            return REQ_W'($urandom_range(513, 2048));
        return REQ_W'($urandom_range(2049, 4095));
    endfunction

    // worst-fit placement over the block list, growing the heap if nothing fits
    function automatic wfha_rsp_t heap_alloc(int unsigned req);
        wfha_rsp_t   r;
        int unsigned p;
        int unsigned sz;
        int unsigned best;
        int unsigned best_sz;
        int unsigned grown;
        int unsigned rest;
        bit          found;
        r.block_addr = '0;
        r.status = ST_FAIL;
        p = 0;
        best = 0;
        best_sz = 0;
        found = 1'b0;
        if (req == 0)
            return r;
        for (int n = 0; n < MAX_WALK && p < top_off && p < HEAP_BYTES; n++)
        begin
            sz = 32'(hdr_size[p]);
            if (!hdr_used[p] && sz >= req && (!found || sz > best_sz))
            begin
                found = 1'b1;
                best = p;
                best_sz = sz;
            end
            p = p + HEADER_BYTES + sz;
        end
        if (!found)
        begin
            grown = ((req + GROW_UNIT - 1) / GROW_UNIT) * GROW_UNIT;
            if (top_off + HEADER_BYTES + grown > HEAP_BYTES || top_off >= HEAP_BYTES)
                return r;
            best = top_off;
            best_sz = grown;
            top_off = top_off + HEADER_BYTES + grown;
        end
        hdr_used[best] = 1'b1;
        hdr_size[best] = SIZE_W'(best_sz);
        // split off the tail when more than one header is left over
        if (best_sz - req > HEADER_BYTES)
        begin
            rest = best + HEADER_BYTES + req;
            if (rest < HEAP_BYTES)
            begin
                hdr_used[rest] = 1'b0;
                hdr_size[rest] = SIZE_W'(best_sz - req - HEADER_BYTES);
                hdr_size[best] = SIZE_W'(req);
            end
        end
        r.block_addr = base_q + best + HEADER_BYTES;
        r.status = ST_OK;
        return r;
    endfunction

    // release: the address must hit a header on the block list
    function automatic wfha_rsp_t heap_release(logic [DATA_W-1:0] addr);
        wfha_rsp_t         r;
        logic [DATA_W-1:0] off;
        int unsigned       p;
        r.block_addr = '0;
        r.status = ST_FAIL;
        off = addr - base_q - HEADER_BYTES;
        p = 0;
        if (off >= top_off)
            return r;
        for (int n = 0; n < MAX_WALK && p < top_off && p < HEAP_BYTES; n++)
        begin
            if (p == off)
            begin
                if (hdr_used[p])
                begin
                    hdr_used[p] = 1'b0;
                    r.status = ST_OK;
                end
                else
                    r.status = ST_DOUBLE;
                return r;
            end
            if (p > off)
                return r;
            p = p + HEADER_BYTES + 32'(hdr_size[p]);
        end
        return r;
    endfunction

    function automatic wfha_rsp_t heap_step(logic [OP_W-1:0] op, logic [REQ_W-1:0] req,
                                            logic [DATA_W-1:0] addr);
        wfha_rsp_t r;
        r.block_addr = '0;
        r.status = ST_FAIL;
        case (op)
            OP_ALLOC:   r = heap_alloc(32'(req));
            OP_RELEASE: r = heap_release(addr);
            OP_CLEAR:
            begin
                top_off = 0;
                r.status = ST_OK;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void drop_off(ref int unsigned q [$], input int unsigned off);
        for (int i = 0; i < q.size(); i++)
        begin
            if (q[i] == off)
            begin
                q.delete(i);
                return;
            end
        end
    endfunction

    // one input transfer, then the expected result and bookkeeping
    task automatic issue_op(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                            input logic [DATA_W-1:0] addr, output wfha_rsp_t rsp);
        int                gap;
        logic [DATA_W-1:0] off;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        req_bytes    <= req;
        release_addr <= addr;
        do
            @(posedge clk);
        while (in_stall);
        rsp = heap_step(op, req, addr);
        pending_rsp.push_back(rsp);
        items_sent++;
        off = (op == OP_ALLOC) ? rsp.block_addr - base_q - HEADER_BYTES
                               : addr - base_q - HEADER_BYTES;
        if (rsp.status == ST_OK)
        begin
            case (op)
                OP_ALLOC:
                begin
                    drop_off(freed_offs, off);
                    live_offs.push_back(off);
                    allocs_ok++;
                end
                OP_RELEASE:
                begin
                    drop_off(live_offs, off);
                    freed_offs.push_back(off);
                    releases_ok++;
                end
                OP_CLEAR:
                begin
                    live_offs.delete();
                    freed_offs.delete();
                end
                default: ;
            endcase
        end
        else
            rejected++;
    endtask

    // stop sending and wait for every result
    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // heap_base write while the block is idle
    task automatic write_base(input logic [DATA_W-1:0] value);
        drain();
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        base_q = value;
        cfg_writes++;
    endtask

    // mostly allocate and release of live blocks, some misuse and noise
    task automatic run_random(input int count);
        wfha_rsp_t         r;
        logic [OP_W-1:0]   op;
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] addr;
        int                pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            req  = REQ_W'($urandom);
            addr = $urandom;
            if (pick < 46 || (pick < 80 && live_offs.size() == 0))
            begin
                op  = OP_ALLOC;
                req = pick_req();
            end
            else if (pick < 80)
            begin
                op   = OP_RELEASE;
                addr = base_q + live_offs[$urandom_range(0, live_offs.size() - 1)]
                       + HEADER_BYTES;
            end
            else if (pick < 86 && freed_offs.size() != 0)
            begin
                op   = OP_RELEASE;
                addr = base_q + freed_offs[$urandom_range(0, freed_offs.size() - 1)]
                       + HEADER_BYTES;
            end
            else if (pick < 93)
            begin
                op = OP_RELEASE;
                case ($urandom_range(0, 3))
                    0: addr = $urandom;
                    1: addr = base_q + top_off + HEADER_BYTES + $urandom_range(0, 64);
                    2: addr = base_q;
                    default: addr = base_q + $urandom_range(0, HEAP_BYTES) + HEADER_BYTES;
                endcase
            end
            else if (pick < 97)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            issue_op(op, req, addr, r);
            // empty a full heap now and then so the walk keeps changing
            if (op == OP_ALLOC && r.status == ST_FAIL && $urandom_range(0, 3) == 0)
                issue_op(OP_CLEAR, REQ_W'($urandom), $urandom, r);
        end
    endtask

    // field extremes and each corner of placement and release
    task automatic test_directed();
        wfha_rsp_t r;
        wfha_rsp_t a;
        wfha_rsp_t b;
        wfha_rsp_t blk [4];
        write_base(32'h0000_1000);
        issue_op(OP_CLEAR, '0, '0, r);
        // zero request and one too large to fit with its header
        issue_op(OP_ALLOC, 12'd0, 32'hFFFF_FFFF, r);
        issue_op(OP_ALLOC, 12'hFFF, 32'h0000_0000, r);
        // two blocks ending exactly at the region end, then heap full
        issue_op(OP_ALLOC, 12'd2016, '0, a);
        issue_op(OP_ALLOC, 12'd2032, '0, b);
        issue_op(OP_ALLOC, 12'd1, '0, r);
        // release, double release, address inside a block, wrapped offset
        issue_op(OP_RELEASE, '0, a.block_addr, r);
        issue_op(OP_RELEASE, '0, a.block_addr, r);
        issue_op(OP_RELEASE, '0, a.block_addr + 1, r);
        issue_op(OP_RELEASE, '0, 32'h0000_0000, r);
        // reuse with a split, then an exact fit of the remainder
        issue_op(OP_ALLOC, 12'd1, '0, r);
        issue_op(OP_ALLOC, 12'd1999, '0, r);
        issue_op(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF, r);
        // after a heap reset an old address lies past the top
        issue_op(OP_CLEAR, '0, '0, r);
        issue_op(OP_RELEASE, '0, b.block_addr, r);
        // a leftover of one header is kept, one byte more is split
        issue_op(OP_ALLOC, 12'd16, '0, r);
        issue_op(OP_ALLOC, 12'd15, '0, r);
        // equal free blocks go to the first, otherwise the largest wins
        issue_op(OP_CLEAR, '0, '0, r);
        issue_op(OP_ALLOC, 12'd64, '0, blk[0]);
        issue_op(OP_ALLOC, 12'd200, '0, blk[1]);
        issue_op(OP_ALLOC, 12'd64, '0, blk[2]);
        issue_op(OP_ALLOC, 12'd8, '0, blk[3]);
        issue_op(OP_RELEASE, '0, blk[0].block_addr, r);
        issue_op(OP_RELEASE, '0, blk[2].block_addr, r);
        issue_op(OP_ALLOC, 12'd40, '0, r);
        issue_op(OP_RELEASE, '0, blk[1].block_addr, r);
        issue_op(OP_ALLOC, 12'd40, '0, r);
        drain();
    endtask

    // heap_base at its extremes, addresses wrapping past the top
    task automatic test_base_extremes();
        logic [DATA_W-1:0] bases [4];
        bases = '{32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h8000_0000, 32'h0000_0000};
        foreach (bases[i])
        begin
            write_base(bases[i]);
            run_random(40);
        end
        drain();
    endtask

    // long random run over several heap_base settings
    task automatic test_random_mix();
        for (int k = 0; k < 5; k++)
        begin
            write_base($urandom);
            no_idle = (k == 2);
            run_random(CHUNK_ITEMS);
        end
        no_idle = 1'b0;
        drain();
    endtask

    // result check and receiver stall
    initial
    begin : result_check
        int        stall_left;
        wfha_rsp_t want;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("result with nothing pending: block_addr %h status %0d",
                           block_addr, status);
                    fails++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    results_seen++;
                    if (block_addr !== want.block_addr)
                    begin
                        $error("block_addr expected %h actual %h", want.block_addr, block_addr);
                        fails++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, status);
                        fails++;
                    end
                end
            end
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap();
            out_stall <= (stall_left > 0);
        end
    end

    // main sequence
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= OP_ALLOC;
        req_bytes    <= '0;
        release_addr <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        no_idle = 1'b0;
        top_off = 0;
        base_q  = '0;
        for (int i = 0; i < HEAP_BYTES; i++)
        begin
            hdr_used[i] = 1'b0;
            hdr_size[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_base_extremes();
        test_random_mix();

        drain();
        repeat (32) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            $error("%0d results never arrived", pending_rsp.size());
            fails++;
        end
        $display("covered %0d transfers in, %0d results checked, %0d heap_base writes",
                 items_sent, results_seen, cfg_writes);
        $display("placed %0d blocks, released %0d, rejected %0d requests",
                 allocs_ok, releases_ok, rejected);
        if (fails == 0)
            $display("worst_fit_heap_allocator_top regression: pass");
        else
            $display("worst_fit_heap_allocator_top regression: fail");
        $finish;
    end

    // run limit
    initial
    begin
        #60_000_000;
        $display("worst_fit_heap_allocator_top regression: fail");
        $finish;
    end

endmodule
